@@ hw/rtl/sobel_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared widths, register indexes and default parameter values.
// ----------------------------------------------------------------------------
package sobel_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int PIXEL_BITS_DEF  = 8;

  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 13;
  localparam int ROW_BITS        = 12;
  localparam int MAG_BITS        = 11;

  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 13;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET   = 11'd1024;
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET  = 13'd1024;
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_LIMIT  = 13'd4096;
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_MIN    = 13'd3;

endpackage

@@ hw/rtl/sobel_edge_magnitude.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude
// 3x3 Sobel |Gx|+|Gy| over a raster pixel stream with two line buffers.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock in raster order, unless the output stalls, and
// returns |Gx|+|Gy| for every interior pixel, one result per beat, (width-2)
// x (height-2) per frame, with row_end and frame_end marking the last result
// of a row and of the frame. A result follows the pixel at row+1, column+1:
// that pixel's line buffer read is registered in the stage, then the result
// in the output register. Both line buffers share one synchronous memory of
// MAX_WIDTH entries, read once and written once per pixel, so the sustained
// rate is one pixel per clock unless the output stalls. After reset the block
// zeroes that memory and takes no pixel during that time; register writes
// are taken at any time but belong between frames or while the block is idle.
module sobel_edge_magnitude
  import sobel_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      pixel_valid,
  output logic                      pixel_ready,
  input  logic [PIXEL_BITS-1:0]     pixel,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic [MAG_BITS-1:0]       magnitude,
  output logic                      row_end,
  output logic                      frame_end
);

  localparam int ADDR_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW        = (WIDTH_REG_BITS > ADDR_BITS + 1) ? WIDTH_REG_BITS
                                                              : ADDR_BITS + 1;
  localparam int GW        = PIXEL_BITS + 4;
  localparam int MAGX      = (GW > MAG_BITS) ? GW : MAG_BITS;

  localparam logic [EW-1:0]        WIDTH_MIN = EW'(3);
  localparam logic [EW-1:0]        WIDTH_MAX = EW'(MAX_WIDTH);
  localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(MAX_WIDTH - 1);

  // Configuration registers.
  logic [WIDTH_REG_BITS-1:0]  image_width;
  logic [HEIGHT_REG_BITS-1:0] image_height;

  // Frame position of the next pixel.
  logic [ADDR_BITS-1:0] column_count;
  logic [ROW_BITS-1:0]  row_count;

  // Line buffer memory: upper row in the high half, middle row in the low.
  logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
  logic [2*PIXEL_BITS-1:0] line_rd;
  logic                    mem_we;
  logic [ADDR_BITS-1:0]    mem_waddr;
  logic [2*PIXEL_BITS-1:0] mem_wdata;

  // Clearing pass after reset.
  logic                 clr_busy;
  logic [ADDR_BITS-1:0] clr_addr;

  // Stage holding the pixel whose line buffer read is in flight.
  logic                  st_valid;
  logic [PIXEL_BITS-1:0] st_pixel;
  logic [ADDR_BITS-1:0]  st_slot;
  logic                  st_interior;
  logic                  st_last_col;
  logic                  st_last_row;
  logic                  st_adv;

  // Window: columns c-2 and c-1 of the top, middle and bottom rows.
  logic [PIXEL_BITS-1:0] win_a, win_d, win_g, win_b, win_e, win_h;

  logic [EW-1:0]              width_eff;
  logic [HEIGHT_REG_BITS-1:0] height_eff;
  logic                       last_col;
  logic                       last_row;
  logic                       in_fire;

  logic [PIXEL_BITS-1:0] top_px;
  logic [PIXEL_BITS-1:0] mid_px;
  logic signed [GW-1:0]  sa, sb, sc, sd, sf, sg, sh, si;
  logic signed [GW-1:0]  gx, gy;
  logic [GW-1:0]         abs_gx, abs_gy;
  logic [GW-1:0]         mag_full;
  logic [MAGX-1:0]       mag_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range sizes act as the nearest legal size.
  always_comb begin
    if (EW'(image_width) < WIDTH_MIN) begin
      width_eff = WIDTH_MIN;
    end else if (EW'(image_width) > WIDTH_MAX) begin
      width_eff = WIDTH_MAX;
    end else begin
      width_eff = EW'(image_width);
    end
    if (image_height < HEIGHT_MIN) begin
      height_eff = HEIGHT_MIN;
    end else if (image_height > HEIGHT_LIMIT) begin
      height_eff = HEIGHT_LIMIT;
    end else begin
      height_eff = image_height;
    end
  end

  assign last_col = EW'(column_count) >= (width_eff - EW'(1));
  assign last_row = HEIGHT_REG_BITS'(row_count) >= (height_eff - HEIGHT_REG_BITS'(1));

  // The stage moves on unless it holds a result that the output cannot take.
  assign st_adv      = st_valid && (!st_interior || !result_valid || result_ready);
  assign pixel_ready = !clr_busy && (!st_valid || st_adv);
  assign in_fire     = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + ADDR_BITS'(1);
      if (clr_addr == LAST_ADDR) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_fire) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + ROW_BITS'(1);
      end else begin
        column_count <= column_count + ADDR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_fire) begin
      st_valid <= 1'b1;
    end else if (st_adv) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      st_pixel    <= pixel;
      st_slot     <= column_count;
      st_interior <= (column_count >= ADDR_BITS'(2)) && (row_count >= ROW_BITS'(2));
      st_last_col <= last_col;
      st_last_row <= last_row;
    end
  end

  // Consecutive pixels always use different slots, so the read of a new
  // pixel never meets the write-back of the one before it.
  always_comb begin
    if (clr_busy) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = st_adv;
      mem_waddr = st_slot;
      mem_wdata = {mid_px, st_pixel};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      line_rd <= line_mem[column_count];
    end
  end

  assign top_px = line_rd[2*PIXEL_BITS-1:PIXEL_BITS];
  assign mid_px = line_rd[PIXEL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      win_a <= '0;
      win_d <= '0;
      win_g <= '0;
      win_b <= '0;
      win_e <= '0;
      win_h <= '0;
    end else if (st_adv) begin
      win_a <= win_b;
      win_d <= win_e;
      win_g <= win_h;
      win_b <= top_px;
      win_e <= mid_px;
      win_h <= st_pixel;
    end
  end

  assign sa = signed'(GW'(win_a));
  assign sb = signed'(GW'(win_b));
  assign sc = signed'(GW'(top_px));
  assign sd = signed'(GW'(win_d));
  assign sf = signed'(GW'(mid_px));
  assign sg = signed'(GW'(win_g));
  assign sh = signed'(GW'(win_h));
  assign si = signed'(GW'(st_pixel));

  assign gx = (sc + (sf <<< 1) + si) - (sa + (sd <<< 1) + sg);
  assign gy = (sa + (sb <<< 1) + sc) - (sg + (sh <<< 1) + si);

  assign abs_gx   = gx[GW-1] ? GW'(-gx) : GW'(gx);
  assign abs_gy   = gy[GW-1] ? GW'(-gy) : GW'(gy);
  assign mag_full = abs_gx + abs_gy;
  assign mag_ext  = MAGX'(mag_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (st_adv && st_interior) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_adv && st_interior) begin
      magnitude <= mag_ext[MAG_BITS-1:0];
      row_end   <= st_last_col;
      frame_end <= st_last_col && st_last_row;
    end
  end

  // The frame's final result is also the last of its row.
  a_frame_end_row_end: assert property (
    @(posedge clk) disable iff (rst)
    (result_valid && frame_end) |-> row_end
  ) else $error("frame_end without row_end");

  // A stalled stage must keep its line buffer data.
  a_read_data_held: assert property (
    @(posedge clk) disable iff (rst)
    (st_valid && !st_adv) |=> $stable(line_rd)
  ) else $error("line buffer read data changed under a stall");

  // No pixel enters and the stage stays empty while the memory is cleared.
  a_clear_idle: assert property (
    @(posedge clk) disable iff (rst)
    clr_busy |-> (!st_valid && !result_valid)
  ) else $error("pixel activity during line buffer clear");

endmodule
